// ===== hw/rtl/fslf_pkg.sv =====
// Shared types, constants and helpers for the fixed-string line filter.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
`default_nettype none

package fslf_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned MaxText    = 65536;
  localparam int unsigned PosW       = $clog2(MaxText);
  localparam int unsigned LenW       = PosW + 1;
  localparam int unsigned PlenW      = $clog2(MaxPattern) + 1;
  localparam int unsigned PidxW      = $clog2(MaxPattern);

  localparam int unsigned DataW      = 64;
  localparam int unsigned AddrW      = 6;

  localparam logic [7:0] ChNul       = 8'd0;
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChUpperA    = 8'd65;
  localparam logic [7:0] ChUpperZ    = 8'd90;
  localparam logic [7:0] CaseOffset  = 8'd32;

  typedef enum logic [2:0] {
    RegPatLow  = 3'd0,
    RegPatHigh = 3'd1,
    RegPatLen  = 3'd2,
    RegIgnCase = 3'd3,
    RegInvert  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] pat;
    logic [PlenW-1:0]           plen;     // saturated to MaxPattern
    logic                       ign_case;
    logic                       invert;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] start;
    logic [LenW-1:0] len;
    logic            found;
    logic            done;
    logic            too_big;
  } line_ent_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ign_case);
    logic [7:0] r;
    r = c;
    if (ign_case && (c >= ChUpperA) && (c <= ChUpperZ)) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fslf_regs.sv =====
// APB-style configuration registers of the line filter.
// Depends on fslf_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module fslf_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [fslf_pkg::AddrW-1:0] paddr,
  input  wire logic [fslf_pkg::DataW-1:0] pwdata,
  output logic      [fslf_pkg::DataW-1:0] prdata,
  output logic                          pready,
  output fslf_pkg::cfg_t                cfg_o
);

  logic [63:0]                  pat_low_q, pat_low_d;
  logic [63:0]                  pat_high_q, pat_high_d;
  logic [fslf_pkg::PlenW-1:0]   plen_q, plen_d;
  logic                         ign_case_q, ign_case_d;
  logic                         invert_q, invert_d;
  logic                         wr_en;
  fslf_pkg::reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = fslf_pkg::reg_idx_e'(paddr[5:3]);

  always_comb begin
    pat_low_d  = pat_low_q;
    pat_high_d = pat_high_q;
    plen_d     = plen_q;
    ign_case_d = ign_case_q;
    invert_d   = invert_q;
    if (wr_en) begin
      case (idx)
        fslf_pkg::RegPatLow:  pat_low_d  = pwdata;
        fslf_pkg::RegPatHigh: pat_high_d = pwdata;
        fslf_pkg::RegPatLen:  plen_d     = pwdata[fslf_pkg::PlenW-1:0];
        fslf_pkg::RegIgnCase: ign_case_d = pwdata[0];
        fslf_pkg::RegInvert:  invert_d   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      plen_q     <= '0;
      ign_case_q <= 1'b0;
      invert_q   <= 1'b0;
    end else begin
      pat_low_q  <= pat_low_d;
      pat_high_q <= pat_high_d;
      plen_q     <= plen_d;
      ign_case_q <= ign_case_d;
      invert_q   <= invert_d;
    end
  end

  always_comb begin
    case (idx)
      fslf_pkg::RegPatLow:  prdata = pat_low_q;
      fslf_pkg::RegPatHigh: prdata = pat_high_q;
      fslf_pkg::RegPatLen:  prdata = {{(fslf_pkg::DataW-fslf_pkg::PlenW){1'b0}}, plen_q};
      fslf_pkg::RegIgnCase: prdata = {{(fslf_pkg::DataW-1){1'b0}}, ign_case_q};
      fslf_pkg::RegInvert:  prdata = {{(fslf_pkg::DataW-1){1'b0}}, invert_q};
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.pat      = {pat_high_q, pat_low_q};
    cfg_o.ign_case = ign_case_q;
    cfg_o.invert   = invert_q;
    // saturate the pattern length
    if (plen_q > fslf_pkg::PlenW'(fslf_pkg::MaxPattern)) begin
      cfg_o.plen = fslf_pkg::PlenW'(fslf_pkg::MaxPattern);
    end else begin
      cfg_o.plen = plen_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fslf_front.sv =====
// Front end: takes text bytes, runs the shift-and match, cuts lines.
// Depends on fslf_pkg; pushes one line entry per line end into the queue.
`default_nettype none

module fslf_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fslf_pkg::cfg_t       cfg_i,
  input  wire logic                 byte_valid_i,
  output logic                      byte_ready_o,
  input  wire logic [7:0]           text_byte_i,
  input  wire logic                 buffer_end_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output fslf_pkg::line_ent_t       ent_o
);

  logic [fslf_pkg::MaxPattern-1:0] pmv_q, pmv_d, pmv_eff, pmv_new, eq;
  logic                            found_q, found_d, found_eff, found_new;
  logic [fslf_pkg::PosW-1:0]       start_q, start_d, start_eff;
  logic [fslf_pkg::LenW-1:0]       len_q, len_d, len_eff, len_new;
  logic                            fin_q, fin_d;
  logic                            accept, is_nul, is_nl, forced, done, emit;
  logic [fslf_pkg::LenW-1:0]       pos;
  logic [7:0]                      fb;
  logic [fslf_pkg::PidxW-1:0]      top_idx;
  logic [fslf_pkg::PosW-1:0]       start_next;

  assign byte_ready_o = !q_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign is_nul       = (text_byte_i == fslf_pkg::ChNul);
  assign is_nl        = (text_byte_i == fslf_pkg::ChNewline);

  // a finished text restarts from offset zero on its next byte
  assign pmv_eff   = fin_q ? '0 : pmv_q;
  assign found_eff = fin_q ? 1'b0 : found_q;
  assign start_eff = fin_q ? '0 : start_q;
  assign len_eff   = fin_q ? '0 : len_q;

  assign pos    = {1'b0, start_eff} + len_eff;
  assign forced = pos >= fslf_pkg::LenW'(fslf_pkg::MaxText - 1);
  assign fb     = fslf_pkg::fold_byte(text_byte_i, cfg_i.ign_case);

  always_comb begin
    for (int i = 0; i < fslf_pkg::MaxPattern; i++) begin
      eq[i] = (fslf_pkg::PlenW'(i) < cfg_i.plen) &&
              (fslf_pkg::fold_byte(cfg_i.pat[i], cfg_i.ign_case) == fb);
    end
  end

  assign top_idx = fslf_pkg::PidxW'(cfg_i.plen - fslf_pkg::PlenW'(1));
  assign pmv_new = is_nul ? pmv_eff
                          : ({pmv_eff[fslf_pkg::MaxPattern-2:0], 1'b1} & eq);
  assign found_new = found_eff ||
                     (!is_nul && (cfg_i.plen != '0) && pmv_new[top_idx]);
  assign len_new   = is_nul ? len_eff : len_eff + fslf_pkg::LenW'(1);

  assign done       = is_nul || buffer_end_i || forced;
  assign emit       = done || is_nl;
  assign push_o     = accept && emit;
  assign start_next = fslf_pkg::PosW'({1'b0, start_eff} + len_new);

  always_comb begin
    ent_o.start   = start_eff;
    ent_o.len     = len_new;
    ent_o.found   = (cfg_i.plen == '0) || found_new;
    ent_o.done    = done;
    ent_o.too_big = done && !is_nul;
  end

  always_comb begin
    pmv_d   = pmv_q;
    found_d = found_q;
    start_d = start_q;
    len_d   = len_q;
    fin_d   = fin_q;
    if (accept) begin
      fin_d = 1'b0;
      if (emit) begin
        pmv_d   = '0;
        found_d = 1'b0;
        len_d   = '0;
        fin_d   = done;
        start_d = done ? start_eff : start_next;
      end else begin
        pmv_d   = pmv_new;
        found_d = found_new;
        len_d   = len_new;
        start_d = start_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmv_q   <= '0;
      found_q <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      pmv_q   <= pmv_d;
      found_q <= found_d;
      start_q <= start_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
    end
  end

  a_too_big_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (ent_o.done || !ent_o.too_big))
    else $error("too_big entry without text end");

  a_line_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_q |-> ({1'b0, start_q} + len_q) < fslf_pkg::LenW'(fslf_pkg::MaxText))
    else $error("line runs past text limit");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (len_q == '0 && pmv_q == '0 && !found_q))
    else $error("line state not cleared after line end");

endmodule

`default_nettype wire

// ===== hw/rtl/fslf_queue.sv =====
// Two-entry queue of line entries between front and back end.
// Depends on fslf_pkg for the line_ent_t entry type.
`default_nettype none

module fslf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fslf_pkg::line_ent_t push_ent_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                nempty_o,
  output fslf_pkg::line_ent_t pop_ent_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  fslf_pkg::line_ent_t ents_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign nempty_o  = (cnt_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && nempty_o;
  assign pop_ent_o = ents_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ents_q[wr_q] <= push_ent_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(Depth)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hw/rtl/fslf_back.sv =====
// Back end: decides keep, tracks the output offset, holds the result register.
// Depends on fslf_pkg; pops line entries from the queue.
`default_nettype none

module fslf_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fslf_pkg::cfg_t        cfg_i,
  input  wire logic                  nempty_i,
  input  wire fslf_pkg::line_ent_t   ent_i,
  output logic                       pop_o,
  output logic                       line_valid_o,
  input  wire logic                  line_ready_i,
  output logic [fslf_pkg::PosW-1:0]  line_start_o,
  output logic [fslf_pkg::LenW-1:0]  line_length_o,
  output logic                       keep_line_o,
  output logic [fslf_pkg::LenW-1:0]  output_offset_o,
  output logic                       text_done_o,
  output logic                       too_big_o
);

  logic                      vld_q, vld_d;
  logic [fslf_pkg::LenW-1:0] kept_q, kept_d;
  logic                      keep;
  logic [fslf_pkg::PosW-1:0] start_q;
  logic [fslf_pkg::LenW-1:0] len_q, offs_q;
  logic                      keep_q, done_q, big_q;

  // take the next entry when the result register is empty or being drained
  assign pop_o = nempty_i && (!vld_q || line_ready_i);
  // short lines are never kept
  assign keep  = (ent_i.len >= fslf_pkg::LenW'(cfg_i.plen)) &&
                 (ent_i.found != cfg_i.invert);

  always_comb begin
    vld_d  = vld_q;
    kept_d = kept_q;
    if (line_ready_i) begin
      vld_d = 1'b0;
    end
    if (pop_o) begin
      vld_d = 1'b1;
      if (ent_i.done) begin
        kept_d = '0;
      end else if (keep) begin
        kept_d = kept_q + ent_i.len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      kept_q <= '0;
    end else begin
      vld_q  <= vld_d;
      kept_q <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      start_q <= ent_i.start;
      len_q   <= ent_i.len;
      keep_q  <= keep;
      offs_q  <= kept_q;
      done_q  <= ent_i.done;
      big_q   <= ent_i.too_big;
    end
  end

  assign line_valid_o    = vld_q;
  assign line_start_o    = start_q;
  assign line_length_o   = len_q;
  assign keep_line_o     = keep_q;
  assign output_offset_o = offs_q;
  assign text_done_o     = done_q;
  assign too_big_o       = big_q;

  a_keep_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && keep_q) |-> (len_q >= fslf_pkg::LenW'(cfg_i.plen)))
    else $error("kept line shorter than pattern");

  a_offs_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && ent_i.done) |=> (kept_q == '0))
    else $error("kept count not cleared at text end");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!vld_q || line_ready_i))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_string_line_filter_top.sv =====
// Top level of the fixed-string line filter: registers, front, queue, back.
// Depends on fslf_pkg, fslf_regs, fslf_front, fslf_queue and fslf_back.
//
//   Channel   Dir   Handshake                   Payload
//   text      in    text_valid_i/text_ready_o   text_byte_i, buffer_end_i
//   line      out   line_valid_o/line_ready_i   line_start_o .. too_big_o
//   config    in    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One text byte a cycle unless the queue is full; results are queued, then registered.
// The match is a 16-bit shift-and vector updated once per accepted byte.
// Reset is asynchronous and clears all control state; no clearing pass.
// A two-entry line queue parts the byte side from the result register, so
// the text side stalls only when two line results wait behind a stalled output.
`default_nettype none

module fixed_string_line_filter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fslf_pkg::AddrW-1:0]    paddr,
  input  wire logic [fslf_pkg::DataW-1:0]    pwdata,
  output logic      [fslf_pkg::DataW-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          text_valid_i,
  output logic                               text_ready_o,
  input  wire logic [7:0]                    text_byte_i,
  input  wire logic                          buffer_end_i,
  output logic                               line_valid_o,
  input  wire logic                          line_ready_i,
  output logic [fslf_pkg::PosW-1:0]          line_start_o,
  output logic [fslf_pkg::LenW-1:0]          line_length_o,
  output logic                               keep_line_o,
  output logic [fslf_pkg::LenW-1:0]          output_offset_o,
  output logic                               text_done_o,
  output logic                               too_big_o
);

  fslf_pkg::cfg_t      cfg;
  fslf_pkg::line_ent_t push_ent, pop_ent;
  logic                push, full, pop, nempty;

  fslf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fslf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (text_valid_i),
    .byte_ready_o (text_ready_o),
    .text_byte_i  (text_byte_i),
    .buffer_end_i (buffer_end_i),
    .q_full_i     (full),
    .push_o       (push),
    .ent_o        (push_ent)
  );

  fslf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .full_o     (full),
    .pop_i      (pop),
    .nempty_o   (nempty),
    .pop_ent_o  (pop_ent)
  );

  fslf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .nempty_i        (nempty),
    .ent_i           (pop_ent),
    .pop_o           (pop),
    .line_valid_o    (line_valid_o),
    .line_ready_i    (line_ready_i),
    .line_start_o    (line_start_o),
    .line_length_o   (line_length_o),
    .keep_line_o     (keep_line_o),
    .output_offset_o (output_offset_o),
    .text_done_o     (text_done_o),
    .too_big_o       (too_big_o)
  );

endmodule

`default_nettype wire

// ===== sim/fslf_line_checker.sv =====
// Line result checker for the fixed-string line filter: follows the register
// port and the text channel, predicts each line report and compares it.
// Depends on fslf_pkg for widths, character codes and register indexes.
module fslf_line_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [fslf_pkg::AddrW-1:0] paddr,
  input  logic [fslf_pkg::DataW-1:0] pwdata,
  input  logic                       text_valid_i,
  input  logic                       text_ready_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       buffer_end_i,
  input  logic                       line_valid_o,
  input  logic                       line_ready_i,
  input  logic [fslf_pkg::PosW-1:0]  line_start_o,
  input  logic [fslf_pkg::LenW-1:0]  line_length_o,
  input  logic                       keep_line_o,
  input  logic [fslf_pkg::LenW-1:0]  output_offset_o,
  input  logic                       text_done_o,
  input  logic                       too_big_o,
  output int unsigned                errors_o,
  output int unsigned                lines_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fslf_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] start;
    logic [LenW-1:0] length;
    logic            keep;
    logic [LenW-1:0] offset;
    logic            done;
    logic            big;
  } line_report_t;

  line_report_t expected_lines[$];

  // register copy
  logic [8*MaxPattern-1:0] pat_q;
  logic [4:0]              pat_len_q;
  logic                    fold_q;
  logic                    invert_q;

  // line tracking
  logic [MaxPattern-1:0] match_vec;
  logic                  line_hit;
  int unsigned           line_start;
  int unsigned           line_len;
  int unsigned           kept_bytes;
  logic                  text_over;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (fold_q && c >= ChUpperA && c <= ChUpperZ) begin
      return c + CaseOffset;
    end
    return c;
  endfunction

  function automatic void apply_write(input logic [AddrW-1:0] addr,
                                      input logic [DataW-1:0] value);
    case (reg_idx_e'(addr[AddrW-1:3]))
      RegPatLow:  pat_q[63:0] = value;
      RegPatHigh: pat_q[127:64] = value;
      RegPatLen:  pat_len_q = value[4:0];
      RegIgnCase: fold_q = value[0];
      RegInvert:  invert_q = value[0];
      default: ;
    endcase
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic bend);
    int unsigned           eff_len;
    int unsigned           i;
    logic [MaxPattern-1:0] eq;
    logic [7:0]            fb;
    logic                  at_limit;
    logic                  ends_text;
    logic                  keep;
    line_report_t          rep;
    eff_len = (pat_len_q > MaxPattern) ? MaxPattern : pat_len_q;
    if (text_over) begin
      line_start = 0;
      line_len   = 0;
      kept_bytes = 0;
      match_vec  = '0;
      line_hit   = 1'b0;
      text_over  = 1'b0;
    end
    at_limit = (line_start + line_len) >= MaxText - 1;
    if (b != ChNul) begin
      line_len++;
      fb = fold_char(b);
      eq = '0;
      for (i = 0; i < eff_len; i++) begin
        eq[i] = (fold_char(pat_q[8*i +: 8]) == fb);
      end
      match_vec = {match_vec[MaxPattern-2:0], 1'b1} & eq;
      if (eff_len != 0 && match_vec[eff_len-1]) begin
        line_hit = 1'b1;
      end
    end
    ends_text = (b == ChNul) || bend || at_limit;
    if (ends_text || b == ChNewline) begin
      // a line shorter than the pattern is dropped in either mode
      keep = (line_len >= eff_len) && ((eff_len == 0 || line_hit) != invert_q);
      rep.start  = PosW'(line_start);
      rep.length = LenW'(line_len);
      rep.keep   = keep;
      rep.offset = LenW'(kept_bytes);
      rep.done   = ends_text;
      rep.big    = ends_text && (b != ChNul);
      expected_lines.push_back(rep);
      if (keep) begin
        kept_bytes += line_len;
      end
      if (ends_text) begin
        text_over = 1'b1;
      end else begin
        line_start += line_len;
      end
      line_len  = 0;
      match_vec = '0;
      line_hit  = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endfunction

  function automatic void check_line();
    line_report_t want;
    if (expected_lines.size() == 0) begin
      $error("line result with no request pending: start %0d length %0d",
             line_start_o, line_length_o);
      errors_o++;
      return;
    end
    want = expected_lines.pop_front();
    check_field("line_start", want.start, line_start_o);
    check_field("line_length", want.length, line_length_o);
    check_field("keep_line", want.keep, keep_line_o);
    check_field("output_offset", want.offset, output_offset_o);
    check_field("text_done", want.done, text_done_o);
    check_field("too_big", want.big, too_big_o);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_lines.delete();
      pat_q           = '0;
      pat_len_q       = '0;
      fold_q          = 1'b0;
      invert_q        = 1'b0;
      match_vec       = '0;
      line_hit        = 1'b0;
      line_start      = 0;
      line_len        = 0;
      kept_bytes      = 0;
      text_over       = 1'b0;
      errors_o        = 0;
      lines_pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr, pwdata);
      end
      if (line_valid_o && line_ready_i) begin
        check_line();
      end
      if (text_valid_i && text_ready_o) begin
        take_byte(text_byte_i, buffer_end_i);
      end
      lines_pending_o = expected_lines.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the fixed-string line filter bench: clock, reset, register writes,
// text stimulus, result stalls, watchdog and verdict.
// Depends on fslf_pkg, fixed_string_line_filter_top and fslf_line_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fslf_pkg::*;

  localparam int unsigned RandomBytes  = 880;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned SettleCycles = 4;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [AddrW-1:0]     paddr        = '0;
  logic [DataW-1:0]     pwdata       = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 text_valid_i = 1'b0;
  logic                 text_ready_o;
  logic [7:0]           text_byte_i  = '0;
  logic                 buffer_end_i = 1'b0;
  logic                 line_valid_o;
  logic                 line_ready_i = 1'b0;
  logic [PosW-1:0]      line_start_o;
  logic [LenW-1:0]      line_length_o;
  logic                 keep_line_o;
  logic [LenW-1:0]      output_offset_o;
  logic                 text_done_o;
  logic                 too_big_o;

  int unsigned          fail_count;
  int unsigned          lines_pending;
  int unsigned          idle_cycles = 0;
  int unsigned          bytes_sent  = 0;
  bit                   calm        = 1'b0;
  logic [8*MaxPattern-1:0] pat_all  = '0;
  int unsigned          pat_len     = 0;

  always #5 clk_i = ~clk_i;

  fixed_string_line_filter_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_valid_i   (text_valid_i),
    .text_ready_o   (text_ready_o),
    .text_byte_i    (text_byte_i),
    .buffer_end_i   (buffer_end_i),
    .line_valid_o   (line_valid_o),
    .line_ready_i   (line_ready_i),
    .line_start_o   (line_start_o),
    .line_length_o  (line_length_o),
    .keep_line_o    (keep_line_o),
    .output_offset_o(output_offset_o),
    .text_done_o    (text_done_o),
    .too_big_o      (too_big_o)
  );

  fslf_line_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .text_valid_i   (text_valid_i),
    .text_ready_o   (text_ready_o),
    .text_byte_i    (text_byte_i),
    .buffer_end_i   (buffer_end_i),
    .line_valid_o   (line_valid_o),
    .line_ready_i   (line_ready_i),
    .line_start_o   (line_start_o),
    .line_length_o  (line_length_o),
    .keep_line_o    (keep_line_o),
    .output_offset_o(output_offset_o),
    .text_done_o    (text_done_o),
    .too_big_o      (too_big_o),
    .errors_o       (fail_count),
    .lines_pending_o(lines_pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (text_valid_i && text_ready_o) || (line_valid_o && line_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each result, none in calm stretches
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        line_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      line_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!line_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic logic [7:0] letter();
    case ($urandom_range(0, 3))
      0:       return "a";
      1:       return "b";
      2:       return "A";
      default: return "B";
    endcase
  endfunction

  function automatic logic [7:0] pattern_char();
    case ($urandom_range(0, 15))
      0:       return 8'($urandom_range(0, 255));
      1:       return ChNewline;
      default: return letter();
    endcase
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input int unsigned len, input bit ign, input bit inv);
    write_reg(RegPatLow, lo);
    write_reg(RegPatHigh, hi);
    write_reg(RegPatLen, DataW'(len));
    write_reg(RegIgnCase, DataW'(ign));
    write_reg(RegInvert, DataW'(inv));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pat_all = {hi, lo};
    pat_len = len;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic bend);
    int unsigned gap;
    bit          hold;
    gap  = calm ? 0 : $urandom_range(0, 17);
    hold = ($urandom_range(0, 299) == 0);
    if (gap != 0 || hold) begin
      text_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      if (hold) begin
        // hold the text side until the line side has drained
        @(negedge clk_i);
        while (lines_pending != 0) @(negedge clk_i);
      end
    end
    text_valid_i <= 1'b1;
    text_byte_i  <= b;
    buffer_end_i <= bend;
    @(posedge clk_i);
    while (!text_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic settle();
    text_valid_i <= 1'b0;
    @(negedge clk_i);
    while (lines_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic random_config();
    logic [8*MaxPattern-1:0] pat;
    int unsigned             len;
    int unsigned             pick;
    int unsigned             i;
    pick = $urandom_range(0, 9);
    for (i = 0; i < MaxPattern; i++) begin
      pat[8*i +: 8] = pattern_char();
    end
    case (pick)
      0: len = 0;
      1: len = MaxPattern;
      2: begin
        pat = {$urandom, $urandom, $urandom, $urandom};
        len = $urandom_range(1, MaxPattern);
      end
      default: len = $urandom_range(1, 4);
    endcase
    load_config(pat[63:0], pat[127:64], len, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  // lines of letters, raw bytes and planted pattern copies, closed in one of
  // several ways: NUL, NUL on the buffer end, or a buffer end without NUL
  task automatic send_text();
    int unsigned lines;
    int unsigned chunks;
    int unsigned l;
    int unsigned c;
    int unsigned k;
    logic [7:0]  b;
    lines = $urandom_range(1, 5);
    for (l = 0; l < lines; l++) begin
      chunks = $urandom_range(0, 4);
      for (c = 0; c < chunks; c++) begin
        case ($urandom_range(0, 3))
          0: begin
            for (k = 0; k < pat_len; k++) begin
              b = pat_all[8*k +: 8];
              if (b == ChNul) begin
                b = "x";
              end
              if ((b | CaseOffset) >= "a" && (b | CaseOffset) <= "z" &&
                  $urandom_range(0, 1)) begin
                b = b ^ CaseOffset;
              end
              send_byte(b, 1'b0);
            end
          end
          3: begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)), 1'b0);
          end
          default: begin
            repeat ($urandom_range(1, 4)) send_byte(letter(), 1'b0);
          end
        endcase
      end
      if (l + 1 < lines) begin
        send_byte(ChNewline, 1'b0);
      end
    end
    case ($urandom_range(0, 9))
      6: send_byte(ChNul, 1'b0);
      7: begin
        send_byte(ChNewline, 1'b0);
        send_byte(ChNul, 1'b1);
      end
      8: send_byte(letter(), 1'b1);
      9: send_byte(ChNewline, 1'b1);
      default: begin
        send_byte(ChNewline, 1'b0);
        send_byte(ChNul, 1'b0);
      end
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 30)) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
    send_byte(ChNul, 1'b0);
  endtask

  initial begin
    int unsigned goal;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: empty pattern keeps every line
    send_byte(ChNul, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChNewline, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(ChNul, 1'b1);
    settle();

    // full-length pattern, folding and invert on; then a short line at buffer end
    load_config('1, '1, MaxPattern, 1'b1, 1'b1);
    repeat (MaxPattern) send_byte(8'hFF, 1'b0);
    send_byte(ChNewline, 1'b0);
    send_byte("q", 1'b1);
    settle();

    goal = bytes_sent + RandomBytes;
    while (bytes_sent < goal) begin
      random_config();
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 7) == 0) begin
          send_noise();
        end else begin
          send_text();
        end
      end
      settle();
    end

    if (fail_count == 0 && lines_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
